FILE: src/hist_pkg.sv
// Shared constants, operation and status codes for the histogram engine.
// No dependencies; every other file of the block but hist_ram refers to this package.
`timescale 1ns / 1ps
`default_nettype none

package hist_pkg;

  localparam int BINS    = 1024;
  localparam int BIN_W   = $clog2(BINS);
  localparam int COUNT_W = 32;
  localparam int DELTA_W = 16;
  localparam int LEAVE_W = 32;
  localparam int TOTAL_W = 40;
  localparam int MODE_W  = 11;
  localparam int MED_W   = 11;
  localparam int SUM_W   = COUNT_W + BIN_W;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_MODE   = 2'd2,
    OP_MEDIAN = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NEGATIVE = 2'd1,
    ST_EMPTY    = 2'd2
  } status_t;

endpackage

`default_nettype wire

FILE: src/hist_if.sv
// Valid/ready channel interfaces for the histogram engine: item in, result out.
// Depends on hist_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface hist_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          op;
  logic [hist_pkg::BIN_W-1:0]          bin;
  logic signed [hist_pkg::DELTA_W-1:0] count;
  logic [hist_pkg::LEAVE_W-1:0]        leave;

  modport source (output valid, output op, output bin, output count, output leave,
                  input ready);
  modport sink (input valid, input op, input bin, input count, input leave,
                output ready);
endinterface

interface hist_out_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         status;
  logic signed [hist_pkg::MODE_W-1:0] mode_bin;
  logic [hist_pkg::MED_W-1:0]         median_x2;
  logic [hist_pkg::LEAVE_W-1:0]       removed;
  logic [hist_pkg::TOTAL_W-1:0]       total_count;

  modport source (output valid, output status, output mode_bin, output median_x2,
                  output removed, output total_count, input ready);
  modport sink (input valid, input status, input mode_bin, input median_x2,
                input removed, input total_count, output ready);
endinterface

`default_nettype wire

FILE: src/hist_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module hist_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: src/hist_core.sv
// Sequencer and datapath of the histogram engine: bin updates, scans, result register.
// Depends on hist_pkg, hist_if and a bin RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module hist_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  hist_in_if.sink                            in_ch,
  hist_out_if.source                         out_ch,
  output logic                               ram_we,
  output logic [hist_pkg::BIN_W-1:0]         ram_waddr,
  output logic [hist_pkg::COUNT_W-1:0]       ram_wdata,
  output logic                               ram_re,
  output logic [hist_pkg::BIN_W-1:0]         ram_raddr,
  input  wire logic [hist_pkg::COUNT_W-1:0]  ram_rdata
);

  localparam int BW  = hist_pkg::BIN_W;
  localparam int CW  = hist_pkg::COUNT_W;
  localparam int TW  = hist_pkg::TOTAL_W;
  localparam int SW  = hist_pkg::SUM_W;
  localparam int MW  = hist_pkg::MODE_W;
  localparam int DW  = hist_pkg::DELTA_W;
  localparam int LW  = hist_pkg::LEAVE_W;
  localparam int AW  = CW + 2;
  localparam int MGW = DW + 1;

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_ADD   = 9'b000000100,
    S_MIN   = 9'b000001000,
    S_SUB   = 9'b000010000,
    S_MODE  = 9'b000100000,
    S_MED   = 9'b001000000,
    S_GAP   = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [BW-1:0]          clr_r, clr_nxt;
  logic [BW:0]            iss_r, iss_nxt;
  logic                   dv_r, dv_nxt;
  logic [BW-1:0]          didx_r, didx_nxt;
  logic [TW-1:0]          total_r, total_nxt;
  logic                   out_valid_r, out_valid_nxt;

  logic [BW-1:0]          bin_r, bin_nxt;
  logic signed [DW-1:0]   count_r, count_nxt;
  logic [LW-1:0]          leave_r, leave_nxt;
  logic [CW-1:0]          val_r, val_nxt;
  logic signed [MW-1:0]   where_r, where_nxt;
  logic [SW-1:0]          sum_r, sum_nxt;
  logic [BW-1:0]          gap_r, gap_nxt;
  logic [CW-1:0]          d_r, d_nxt;

  logic [1:0]             res_status_r, res_status_nxt;
  logic signed [MW-1:0]   res_mode_r, res_mode_nxt;
  logic [MW-1:0]          res_med_r, res_med_nxt;
  logic [LW-1:0]          res_removed_r, res_removed_nxt;

  logic [1:0]             out_status_r, out_status_nxt;
  logic signed [MW-1:0]   out_mode_r, out_mode_nxt;
  logic [MW-1:0]          out_med_r, out_med_nxt;
  logic [LW-1:0]          out_removed_r, out_removed_nxt;
  logic [TW-1:0]          out_total_r, out_total_nxt;

  logic                   in_fire;
  logic                   out_free;
  logic                   last;
  logic                   can_issue;

  // add datapath
  logic signed [AW-1:0]   add_sum;
  logic [CW-1:0]          add_new;
  logic [AW-1:0]          add_up;
  logic [AW-1:0]          add_dn;
  logic [MGW-1:0]         add_mag;
  logic                   add_grow;
  logic [TW:0]            tot_plus;
  logic [TW-1:0]          add_total;

  // scan datapath
  logic [SW-1:0]          med_sum;
  logic [SW-1:0]          med_half;
  logic [SW-1:0]          sub_amt;

  assign in_fire   = in_ch.valid && (state_r == S_IDLE);
  assign out_free  = !out_valid_r || out_ch.ready;
  assign last      = (didx_r == BW'(hist_pkg::BINS - 1));
  assign can_issue = (iss_r < (BW+1)'(hist_pkg::BINS));

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.mode_bin    = out_mode_r;
  assign out_ch.median_x2   = out_med_r;
  assign out_ch.removed     = out_removed_r;
  assign out_ch.total_count = out_total_r;

  always_comb begin
    add_sum  = $signed({2'b00, ram_rdata}) + AW'(count_r);
    add_new  = add_sum[CW] ? {CW{1'b1}} : add_sum[CW-1:0];
    add_up   = {2'b00, add_new} - {2'b00, ram_rdata};
    add_dn   = {2'b00, ram_rdata} - {2'b00, add_new};
    add_grow = (add_new >= ram_rdata);
    add_mag  = add_grow ? add_up[MGW-1:0] : add_dn[MGW-1:0];
    tot_plus = {1'b0, total_r} + (TW+1)'(add_mag);
    if (add_grow) begin
      add_total = tot_plus[TW] ? {TW{1'b1}} : tot_plus[TW-1:0];
    end else if (TW'(add_mag) >= total_r) begin
      add_total = '0;
    end else begin
      add_total = total_r - TW'(add_mag);
    end
    med_sum  = sum_r + SW'(ram_rdata);
    med_half = SW'(total_r[TW-1:1]);
    sub_amt  = {d_r, {BW{1'b0}}};
  end

  always_comb begin
    state_nxt       = state_r;
    clr_nxt         = clr_r;
    iss_nxt         = iss_r;
    dv_nxt          = 1'b0;
    didx_nxt        = didx_r;
    total_nxt       = total_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    bin_nxt         = bin_r;
    count_nxt       = count_r;
    leave_nxt       = leave_r;
    val_nxt         = val_r;
    where_nxt       = where_r;
    sum_nxt         = sum_r;
    gap_nxt         = gap_r;
    d_nxt           = d_r;
    res_status_nxt  = res_status_r;
    res_mode_nxt    = res_mode_r;
    res_med_nxt     = res_med_r;
    res_removed_nxt = res_removed_r;
    out_status_nxt  = out_status_r;
    out_mode_nxt    = out_mode_r;
    out_med_nxt     = out_med_r;
    out_removed_nxt = out_removed_r;
    out_total_nxt   = out_total_r;
    ram_we          = 1'b0;
    ram_waddr       = didx_r;
    ram_wdata       = '0;
    ram_re          = 1'b0;
    ram_raddr       = iss_r[BW-1:0];

    // keep the read stream going in every scan state
    if ((state_r == S_MIN || state_r == S_SUB || state_r == S_MODE ||
         state_r == S_MED || state_r == S_GAP) && can_issue) begin
      ram_re   = 1'b1;
      iss_nxt  = iss_r + (BW+1)'(1);
      dv_nxt   = 1'b1;
      didx_nxt = iss_r[BW-1:0];
    end

    unique case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + BW'(1);
        if (clr_r == BW'(hist_pkg::BINS - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_fire) begin
          bin_nxt         = in_ch.bin;
          count_nxt       = in_ch.count;
          leave_nxt       = in_ch.leave;
          val_nxt         = '0;
          where_nxt       = '1;
          sum_nxt         = '0;
          res_status_nxt  = hist_pkg::ST_OK;
          res_mode_nxt    = '0;
          res_med_nxt     = '0;
          res_removed_nxt = '0;
          ram_re          = 1'b1;
          ram_raddr       = (hist_pkg::op_t'(in_ch.op) == hist_pkg::OP_ADD) ? in_ch.bin : '0;
          iss_nxt         = (BW+1)'(1);
          dv_nxt          = 1'b1;
          didx_nxt        = '0;
          unique case (hist_pkg::op_t'(in_ch.op))
            hist_pkg::OP_ADD:    state_nxt = S_ADD;
            hist_pkg::OP_REMOVE: state_nxt = S_MIN;
            hist_pkg::OP_MODE:   state_nxt = S_MODE;
            hist_pkg::OP_MEDIAN: begin
              if (total_r == '0) begin
                res_status_nxt = hist_pkg::ST_EMPTY;
                state_nxt      = S_DONE;
              end else begin
                state_nxt = S_MED;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end

      S_ADD: begin
        // hold the read data until the result slot frees up
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_mode_nxt    = '0;
          out_med_nxt     = '0;
          out_removed_nxt = '0;
          if (add_sum[AW-1]) begin
            out_status_nxt = hist_pkg::ST_NEGATIVE;
            out_total_nxt  = total_r;
          end else begin
            out_status_nxt = hist_pkg::ST_OK;
            ram_we         = 1'b1;
            ram_waddr      = bin_r;
            ram_wdata      = add_new;
            total_nxt      = add_total;
            out_total_nxt  = add_total;
          end
          state_nxt = S_IDLE;
        end
      end

      S_MIN: begin
        if (dv_r) begin
          if (didx_r == '0 || ram_rdata < val_r) begin
            val_nxt = ram_rdata;
          end
          if (last) begin
            if (val_nxt > leave_r) begin
              d_nxt           = val_nxt - leave_r;
              res_removed_nxt = val_nxt - leave_r;
              // restart the read stream for the subtract sweep
              ram_re          = 1'b1;
              ram_raddr       = '0;
              iss_nxt         = (BW+1)'(1);
              dv_nxt          = 1'b1;
              didx_nxt        = '0;
              state_nxt       = S_SUB;
            end else begin
              state_nxt = S_DONE;
            end
          end
        end
      end

      S_SUB: begin
        if (dv_r) begin
          ram_we    = 1'b1;
          ram_waddr = didx_r;
          ram_wdata = ram_rdata - d_r;
          if (last) begin
            total_nxt = (sub_amt >= SW'(total_r)) ? '0 : (total_r - TW'(sub_amt));
            state_nxt = S_DONE;
          end
        end
      end

      S_MODE: begin
        if (dv_r) begin
          if (ram_rdata > val_r) begin
            val_nxt   = ram_rdata;
            where_nxt = MW'(didx_r);
          end
          if (last) begin
            res_mode_nxt = where_nxt;
            state_nxt    = S_DONE;
          end
        end
      end

      S_MED: begin
        if (dv_r) begin
          sum_nxt = med_sum;
          if (med_sum > med_half) begin
            res_med_nxt = {didx_r, 1'b0};
            state_nxt   = S_DONE;
          end else if (!total_r[0] && med_sum == med_half) begin
            gap_nxt = didx_r;
            if (last) begin
              res_med_nxt = {didx_r, 1'b0};
              state_nxt   = S_DONE;
            end else begin
              state_nxt = S_GAP;
            end
          end else if (last) begin
            res_med_nxt = '0;
            state_nxt   = S_DONE;
          end
        end
      end

      S_GAP: begin
        if (dv_r) begin
          if (ram_rdata != '0) begin
            res_med_nxt = {1'b0, gap_r} + {1'b0, didx_r};
            state_nxt   = S_DONE;
          end else if (last) begin
            res_med_nxt = {gap_r, 1'b0};
            state_nxt   = S_DONE;
          end
        end
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = res_status_r;
          out_mode_nxt    = res_mode_r;
          out_med_nxt     = res_med_r;
          out_removed_nxt = res_removed_r;
          out_total_nxt   = total_r;
          state_nxt       = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      iss_r       <= '0;
      dv_r        <= 1'b0;
      didx_r      <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      iss_r       <= iss_nxt;
      dv_r        <= dv_nxt;
      didx_r      <= didx_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r         <= bin_nxt;
    count_r       <= count_nxt;
    leave_r       <= leave_nxt;
    val_r         <= val_nxt;
    where_r       <= where_nxt;
    sum_r         <= sum_nxt;
    gap_r         <= gap_nxt;
    d_r           <= d_nxt;
    res_status_r  <= res_status_nxt;
    res_mode_r    <= res_mode_nxt;
    res_med_r     <= res_med_nxt;
    res_removed_r <= res_removed_nxt;
    out_status_r  <= out_status_nxt;
    out_mode_r    <= out_mode_nxt;
    out_med_r     <= out_med_nxt;
    out_removed_r <= out_removed_nxt;
    out_total_r   <= out_total_nxt;
  end

endmodule

`default_nettype wire

FILE: src/histogram_mode_median_engine.sv
// Histogram engine with mode and median queries, top level.
// Item channel in_ch: op, bin, count, leave; result channel out_ch: status,
//   mode_bin, median_x2, removed, total_count. One result per item, in order.
// A transaction moves at a rising edge where valid and ready are both high.
// The 1024 bin counters live in one RAM with registered read data; the
//   running total is a register.
// After reset the block sweeps all 1024 bins of the RAM to zero, one bin a cycle,
//   with in_ch.ready low; then in_ch.ready rises.
// One item is in work at a time; in_ch.ready is high only while idle.
// Add: read-modify-write of one bin; the bin is read in the accepting cycle, then
//   written and the result registered in S_ADD once the output register is free.
//   A median of an empty histogram goes straight to S_DONE with status ST_EMPTY.
// Mode and median: one pass reading one bin a cycle, then S_DONE registers the
//   result; the median stops early.
// Remove: a minimum pass and, when bins drop, a subtract pass; then S_DONE
//   registers the result.
// The RAM read port, one bin per cycle, sets the scan lengths.
// When out_ch.ready is low the finished result holds in the output register
//   and the engine holds its final step until the register frees up.
// Depends on hist_pkg, hist_if, hist_ram and hist_core.
`timescale 1ns / 1ps
`default_nettype none

module histogram_mode_median_engine (
  input wire logic   clk,
  input wire logic   rst_n,
  hist_in_if.sink    in_ch,
  hist_out_if.source out_ch
);

  logic                         ram_we;
  logic [hist_pkg::BIN_W-1:0]   ram_waddr;
  logic [hist_pkg::COUNT_W-1:0] ram_wdata;
  logic                         ram_re;
  logic [hist_pkg::BIN_W-1:0]   ram_raddr;
  logic [hist_pkg::COUNT_W-1:0] ram_rdata;

  hist_ram #(
    .DEPTH (hist_pkg::BINS),
    .WIDTH (hist_pkg::COUNT_W)
  ) u_bins (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  hist_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

endmodule

`default_nettype wire
